// ----- sv/dsfd_pkg.sv -----
// Shared types and constants of the string field deframer.
package dsfd_pkg;

  // Message layout.
  localparam int PreludeBytes   = 16;
  localparam int HeaderFields   = 4;
  localparam int FieldAlign     = 8;
  localparam int AlignW         = $clog2(FieldAlign);
  localparam int WordBytes      = 4;
  localparam int BodyLenLastPos = 7;
  localparam int MsgIdLastPos   = 11;
  localparam int EmptyBodyLen   = 4;

  // Depth of the byte queue between the front and the parser.
  localparam int QueueDepth = 2;

  // Parser phases.
  typedef enum logic [2:0] {
    PhPrelude = 3'd0,
    PhHskip   = 3'd1,
    PhHlen    = 3'd2,
    PhHcopy   = 3'd3,
    PhHpad    = 3'd4,
    PhHdisc   = 3'd5,
    PhBlen    = 3'd6,
    PhBcopy   = 3'd7
  } phase_e;

  // Parser state.
  typedef struct packed {
    phase_e      phase;
    logic [31:0] section_remaining;
    logic [31:0] step_count;
    logic [31:0] length_shift;
    logic [31:0] body_bytes;
    logic [31:0] id_register;
    logic [2:0]  fields_done;
  } state_t;

  // One result item.
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        param_last;
    logic        message_end;
    logic [31:0] message_id;
    logic        frame_error;
  } result_t;

endpackage

// ----- sv/dsfd_ifs.sv -----
// Channel interfaces: raw message bytes in, deframed result items out.
interface dsfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface dsfd_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic        param_last;
  logic        message_end;
  logic [31:0] message_id;
  logic        frame_error;

  modport source (output valid, output payload_byte, output payload_valid,
                  output param_last, output message_end, output message_id,
                  output frame_error, input ready);
  modport sink (input valid, input payload_byte, input payload_valid,
                input param_last, input message_end, input message_id,
                input frame_error, output ready);
endinterface

// ----- sv/dbus_string_field_deframer_top.sv -----
// Top level of the string field deframer: byte queue followed by the parser.
//
// Usage: feed one message byte per item on in_i (valid/ready). Every accepted
// byte yields exactly one result item on out_o, carrying the copied string
// byte with its valid and parameter-last flags, the message-end and
// frame-error flags, and the current message id.
// Path: an accepted byte is first stored in the byte queue and is then parsed
// straight into the result register, from which it is offered on out_o.
// Throughput: one byte per cycle sustained while out_o.ready stays high; the
// parser updates all of its counters for a byte at once, and its result
// register drains while the next byte is being parsed.
// Reset: rst_ni is asynchronous and active low. It empties the queue, drops
// any pending result and returns the parser to the start of a prelude with
// all counters, the body length and the message id at zero.
// Stall: when out_o.ready is low the result holds, the parser stops, and the
// two-entry queue fills before in_i.ready falls.
module dbus_string_field_deframer_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  dsfd_byte_if.sink      in_i,
  dsfd_result_if.source  out_o
);
  import dsfd_pkg::*;

  dsfd_byte_if q2p ();

  dsfd_byte_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (q2p.source)
  );

  dsfd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (q2p.sink),
    .out_o  (out_o)
  );

  // A byte that is not copied shows as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.payload_valid) |-> (out_o.payload_byte == 8'd0))
    else $error("uncopied byte carries nonzero payload");

  // A parameter can only end on a copied byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.param_last) |-> out_o.payload_valid)
    else $error("param_last without a copied byte");

  // The parser only takes a byte from the queue when its result slot frees.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !q2p.ready)
    else $error("parser took a byte while its result was stalled");

  // Every byte the parser takes is offered as a result item on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q2p.valid && q2p.ready) |=> out_o.valid)
    else $error("parsed byte produced no result item");

endmodule

// ----- sv/dsfd_byte_fifo.sv -----
// Front end: accepts raw bytes into a short queue ahead of the parser.
module dsfd_byte_fifo (
  input  logic         clk_i,
  input  logic         rst_ni,
  dsfd_byte_if.sink    in_i,
  dsfd_byte_if.source  out_o
);
  import dsfd_pkg::*;

  localparam int PtrW   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CountW = $clog2(QueueDepth + 1);

  logic [7:0]        mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0] count_q, count_d;
  logic              push, pop;

  // Handshakes on both sides.
  assign in_i.ready      = (count_q != CountW'(QueueDepth));
  assign out_o.valid     = (count_q != '0);
  assign out_o.data_byte = mem_q[rd_ptr_q];
  assign push            = in_i.valid && in_i.ready;
  assign pop             = out_o.valid && out_o.ready;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CountW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Byte storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_i.data_byte;
    end
  end

endmodule

// ----- sv/dsfd_parser.sv -----
// Back end: message state machine and registered result item.
module dsfd_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  dsfd_byte_if.sink      in_i,
  dsfd_result_if.source  out_o
);
  import dsfd_pkg::*;

  state_t      state_q, state_d;
  result_t     out_q, res;
  logic        out_valid_q;
  logic        fire;
  logic        end_flag, err_flag;

  // Closes a header field; pad runs until the copied count is aligned.
  function automatic state_t field_complete(state_t st, logic [31:0] copied);
    state_t           r;
    logic [AlignW-1:0] rem;
    r = st;
    rem = AlignW'(copied % 32'(FieldAlign));
    r.fields_done = st.fields_done + 3'd1;
    if (rem != '0) begin
      r.phase = PhHpad;
      r.step_count = 32'(FieldAlign) - {{(32-AlignW){1'b0}}, rem};
    end else if (r.fields_done >= 3'(HeaderFields)) begin
      r.phase = PhHdisc;
    end else begin
      r.phase = PhHskip;
      r.step_count = '0;
    end
    return r;
  endfunction

  // A byte is taken whenever the result register is free or being drained.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign fire       = in_i.valid && in_i.ready;

  // Next state for the byte at the queue head.
  always_comb begin : next_state
    state_t      s;
    logic [31:0] lane, ls_new, step_inc, step_dec, sr_dec, cnt;
    logic        hdr_done, msg_done;
    s        = state_q;
    lane     = {24'b0, in_i.data_byte} << {state_q.step_count[1:0], 3'b000};
    step_inc = state_q.step_count + 32'd1;
    step_dec = state_q.step_count - 32'd1;
    sr_dec   = state_q.section_remaining - 32'd1;
    ls_new   = state_q.length_shift | lane;
    cnt      = ls_new + 32'd1;
    hdr_done = 1'b0;
    msg_done = 1'b0;
    err_flag = 1'b0;
    end_flag = 1'b0;

    case (state_q.phase)
      PhPrelude: begin
        // Little-endian words restart every four bytes.
        if (state_q.step_count[1:0] == 2'd0) begin
          ls_new = lane;
        end
        s.length_shift = ls_new;
        if (state_q.step_count == 32'(BodyLenLastPos)) begin
          s.body_bytes = (ls_new == 32'(EmptyBodyLen)) ? '0 : ls_new;
        end else if (state_q.step_count == 32'(MsgIdLastPos)) begin
          s.id_register = ls_new;
        end
        s.step_count = step_inc;
        if (step_inc >= 32'(PreludeBytes)) begin
          s.section_remaining = ls_new;
          s.fields_done = '0;
          s.step_count = '0;
          s.length_shift = '0;
          if (ls_new != '0) begin
            s.phase = PhHskip;
          end else begin
            hdr_done = 1'b1;
          end
        end
      end
      PhHskip: begin
        s.step_count = step_inc;
        if (step_inc >= 32'(WordBytes)) begin
          s.phase = PhHlen;
          s.step_count = '0;
          s.length_shift = '0;
        end
      end
      PhHlen: begin
        s.length_shift = ls_new;
        s.step_count = step_inc;
        if (step_inc >= 32'(WordBytes)) begin
          // A length of all ones wraps to an empty copy.
          if (cnt == '0) begin
            s = field_complete(s, '0);
          end else begin
            s.phase = PhHcopy;
            s.step_count = cnt;
          end
        end
      end
      PhHcopy: begin
        s.step_count = step_dec;
        if (step_dec == '0) begin
          s = field_complete(s, state_q.length_shift + 32'd1);
        end
      end
      PhHpad: begin
        s.step_count = step_dec;
        if (step_dec == '0) begin
          if (state_q.fields_done >= 3'(HeaderFields)) begin
            s.phase = PhHdisc;
          end else begin
            s.phase = PhHskip;
            s.step_count = '0;
          end
        end
      end
      PhHdisc: begin
        s.phase = PhHdisc;
      end
      PhBlen: begin
        if (state_q.step_count == '0) begin
          ls_new = lane;
        end
        s.length_shift = ls_new;
        s.step_count = step_inc;
        if (step_inc >= 32'(WordBytes)) begin
          s.step_count = '0;
          if ((ls_new + 32'd1) != '0) begin
            s.phase = PhBcopy;
            s.step_count = ls_new + 32'd1;
          end
        end
      end
      PhBcopy: begin
        s.step_count = step_dec;
        if (step_dec == '0) begin
          s.phase = PhBlen;
        end
      end
      default: begin
        s = state_q;
      end
    endcase

    // Section byte counters.
    case (state_q.phase)
      PhHskip, PhHlen, PhHcopy, PhHpad, PhHdisc: begin
        s.section_remaining = sr_dec;
        if (sr_dec == '0) begin
          hdr_done = 1'b1;
        end
      end
      PhBlen, PhBcopy: begin
        s.section_remaining = sr_dec;
        if (sr_dec == '0) begin
          msg_done = 1'b1;
        end
      end
      default: begin
        msg_done = msg_done;
      end
    endcase

    // End of the header: flag missing fields, then body or message end.
    if (hdr_done) begin
      err_flag = (s.fields_done < 3'(HeaderFields));
      if (s.body_bytes != '0) begin
        s.section_remaining = s.body_bytes;
        s.phase = PhBlen;
        s.step_count = '0;
        s.length_shift = '0;
      end else begin
        msg_done = 1'b1;
      end
    end

    if (msg_done) begin
      end_flag = 1'b1;
      s.phase = PhPrelude;
      s.step_count = '0;
      s.length_shift = '0;
    end

    state_d = s;
  end

  // Result fields: copy phases pass the byte, the last one closes a parameter.
  always_comb begin : outputs
    res = '0;
    case (state_q.phase)
      PhHcopy, PhBcopy: begin
        res.payload_valid = 1'b1;
        res.payload_byte  = in_i.data_byte;
        res.param_last    = (state_q.step_count == 32'd1);
      end
      default: begin
        res.payload_valid = 1'b0;
      end
    endcase
    res.message_end = end_flag;
    res.frame_error = err_flag;
    res.message_id  = state_d.id_register;
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PhPrelude, default: '0};
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.payload_byte  = out_q.payload_byte;
  assign out_o.payload_valid = out_q.payload_valid;
  assign out_o.param_last    = out_q.param_last;
  assign out_o.message_end   = out_q.message_end;
  assign out_o.message_id    = out_q.message_id;
  assign out_o.frame_error   = out_q.frame_error;

endmodule
